FILE: rtl/sync_hex_length_deframer_defines.svh
// assertion macros for the sync hex length deframer
// used by the top level only; expects clock and reset in scope
`ifndef SYNC_HEX_LENGTH_DEFRAMER_DEFINES_SVH
`define SYNC_HEX_LENGTH_DEFRAMER_DEFINES_SVH

// checked outside reset
`define SHLD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define SHLD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/shld_pkg.sv
// shared types, constants and the hex decoder of the sync hex length deframer
// no dependencies
`timescale 1ns / 1ps

package shld_pkg;

   localparam int LENGTH_DIGITS = 4;
   localparam int LEN_W         = 16;
   localparam int DIGIT_CNT_W   = 3;

   localparam logic [7:0] SYNC_FIRST   = 8'h4A;
   localparam logic [7:0] SYNC_SECOND  = 8'h53;
   localparam logic [7:0] CARRIAGE_RET = 8'h0D;

   typedef enum logic [1:0] {
      PHASE_WAIT_J  = 2'd0,
      PHASE_WAIT_S  = 2'd1,
      PHASE_LENGTH  = 2'd2,
      PHASE_PAYLOAD = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0]       payload_byte;
      logic             byte_is_last;
      logic             length_error;
      logic [LEN_W-1:0] frame_length;
   } rsp_type;

   typedef struct packed {
      logic main_valid;
      logic skid_valid;
   } buf_status_type;

   // bit 4 set for a hex digit, bits 3:0 its value
   function automatic logic [4:0] hex_decode(logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h41 + 8'd10)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h61 + 8'd10)};
      end
      return r;
   endfunction

endpackage

FILE: rtl/shld_parser.sv
// frame parser: sync hunt, hex length digits and payload count
// depends on shld_pkg
`timescale 1ns / 1ps

module shld_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_fire,
   input  logic [7:0]         in_byte,
   output logic               res_valid,
   output shld_pkg::rsp_type  res
);
   import shld_pkg::*;

   phase_type              phase_ff,  phase_in;
   logic [LEN_W-1:0]       length_ff, length_in;
   logic [DIGIT_CNT_W-1:0] digits_ff, digits_in;
   logic [LEN_W-1:0]       count_ff,  count_in;

   logic [4:0]             hex;
   logic [DIGIT_CNT_W-1:0] digits_next;
   logic [LEN_W-1:0]       count_next;
   logic                   is_cr;
   logic                   last;

   assign hex         = hex_decode(in_byte);
   assign digits_next = DIGIT_CNT_W'(digits_ff + DIGIT_CNT_W'(1));
   assign count_next  = LEN_W'(count_ff + LEN_W'(1));
   assign is_cr       = (in_byte == CARRIAGE_RET);
   assign last        = (count_next >= length_ff) || (count_next == '0);

   // next state
   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      digits_in = digits_ff;
      count_in  = count_ff;
      if (in_fire && !is_cr) begin
         unique case (phase_ff)
            PHASE_WAIT_J: begin
               if (in_byte == SYNC_FIRST) phase_in = PHASE_WAIT_S;
            end
            PHASE_WAIT_S: begin
               if (in_byte == SYNC_SECOND) begin
                  phase_in  = PHASE_LENGTH;
                  length_in = '0;
                  digits_in = '0;
               end else if (in_byte != SYNC_FIRST) begin
                  phase_in = PHASE_WAIT_J;
               end
            end
            PHASE_LENGTH: begin
               if (!hex[4]) begin
                  phase_in  = PHASE_WAIT_J;
                  length_in = '0;
                  digits_in = '0;
                  count_in  = '0;
               end else begin
                  length_in = {length_ff[LEN_W-5:0], hex[3:0]};
                  digits_in = digits_next;
                  if (digits_next >= DIGIT_CNT_W'(LENGTH_DIGITS)) begin
                     phase_in = PHASE_PAYLOAD;
                     count_in = '0;
                  end
               end
            end
            PHASE_PAYLOAD: begin
               if (last) begin
                  phase_in  = PHASE_WAIT_J;
                  length_in = '0;
                  digits_in = '0;
                  count_in  = '0;
               end else begin
                  count_in = count_next;
               end
            end
            default: phase_in = PHASE_WAIT_J;
         endcase
      end
   end

   // result
   always_comb begin
      res_valid        = 1'b0;
      res.payload_byte = '0;
      res.byte_is_last = 1'b0;
      res.length_error = 1'b0;
      res.frame_length = '0;
      if (in_fire && !is_cr) begin
         unique case (phase_ff)
            PHASE_LENGTH: begin
               if (!hex[4]) begin
                  res_valid        = 1'b1;
                  res.length_error = 1'b1;
               end
            end
            PHASE_PAYLOAD: begin
               res_valid        = 1'b1;
               res.payload_byte = in_byte;
               res.byte_is_last = last;
               res.frame_length = length_ff;
            end
            default: res_valid = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_WAIT_J;
         length_ff <= '0;
         digits_ff <= '0;
         count_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         digits_ff <= digits_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/shld_out_buf.sv
// two-entry result buffer: output register plus skid register
// depends on shld_pkg
`timescale 1ns / 1ps

module shld_out_buf (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  shld_pkg::rsp_type         push_data,
   output logic                      full,
   output logic                      out_valid,
   output shld_pkg::rsp_type         out_data,
   input  logic                      out_stall,
   output shld_pkg::buf_status_type  status
);
   import shld_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    take;

   assign take = main_valid_ff && !out_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || take) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else if (push) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (push && !skid_valid_ff) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full              = skid_valid_ff;
   assign out_valid         = main_valid_ff;
   assign out_data          = main_ff;
   assign status.main_valid = main_valid_ff;
   assign status.skid_valid = skid_valid_ff;

endmodule

FILE: rtl/sync_hex_length_deframer.sv
// top level of the sync hex length deframer
// depends on shld_pkg, shld_parser, shld_out_buf and the assertion macro header
//
// Takes one received byte per cycle while req_stall is low and answers with at most
// one result item per byte, registered in the output buffer: each payload byte of a
// 'J' 'S' <4 hex digits> frame, or an error item when a length character is not hex.
// Carriage returns are dropped everywhere. The frame state updates once per accepted
// byte and the results go through a two-entry output buffer, so req_stall rises only
// when both entries hold results that the consumer has not yet taken.
`timescale 1ns / 1ps
`include "sync_hex_length_deframer_defines.svh"

module sync_hex_length_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_byte_is_last,
   output logic        rsp_length_error,
   output logic [15:0] rsp_frame_length
);
   import shld_pkg::*;

   logic           in_fire;
   logic           res_valid;
   rsp_type        res;
   rsp_type        out_data;
   logic           buf_full;
   buf_status_type buf_status;

   assign in_fire   = req_valid && !req_stall;
   assign req_stall = buf_full;

   shld_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_fire   (in_fire),
      .in_byte   (req_rx_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   shld_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .out_stall (rsp_stall),
      .status    (buf_status)
   );

   assign rsp_payload_byte = out_data.payload_byte;
   assign rsp_byte_is_last = out_data.byte_is_last;
   assign rsp_length_error = out_data.length_error;
   assign rsp_frame_length = out_data.frame_length;

   `SHLD_ASSERT(a_error_item_clean, rsp_valid && rsp_length_error |-> rsp_payload_byte == 8'd0 && !rsp_byte_is_last && rsp_frame_length == 16'd0, "error item carries payload data")
   `SHLD_ASSERT_ALWAYS(a_skid_behind_main, buf_status.skid_valid |-> buf_status.main_valid, "skid entry held without output entry")
   `SHLD_ASSERT(a_skid_fill_stalls, res_valid && rsp_valid && rsp_stall |=> req_stall, "result parked without stalling input")

endmodule

FILE: tb/tb_sync_hex_length_deframer.sv
// self-checking testbench for sync_hex_length_deframer: directed rows and random
// framed traffic, scored against a cycle-free parser model or a typed row's result
// depends on shld_pkg and the deframer rtl
`timescale 1ns / 1ps

module tb_sync_hex_length_deframer;
   import shld_pkg::*;

   typedef struct packed {
      logic [7:0] rx;
      logic       typed;
      rsp_type    rsp;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_byte_is_last;
   logic        rsp_length_error;
   logic [15:0] rsp_frame_length;

   logic        row_typed = 1'b0;
   rsp_type     row_rsp = '0;

   phase_type   phase;
   logic [15:0] len_acc;
   logic [2:0]  digit_cnt;
   logic [15:0] pay_cnt;

   rsp_type      awaited_rsps[$];
   stim_row_type directed_rows[$];
   int           mismatch_count = 0;
   bit           quiet = 1'b0;

   sync_hex_length_deframer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_is_last (rsp_byte_is_last),
      .rsp_length_error (rsp_length_error),
      .rsp_frame_length (rsp_frame_length)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // bit 4 flags a hex digit, bits 3:0 hold its value
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) begin
         return {1'b1, b[3:0]};
      end
      if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
         return {1'b1, b[3:0] + 4'd9};
      end
      return 5'd0;
   endfunction

   function automatic stim_row_type pred_row(input logic [7:0] b);
      return {b, 1'b0, 26'd0};
   endfunction

   function automatic stim_row_type typed_row(input logic [7:0] b, input logic [7:0] pb,
                                              input logic last, input logic err,
                                              input logic [15:0] len);
      return {b, 1'b1, pb, last, err, len};
   endfunction

   task automatic clear_frame;
      phase     = PHASE_WAIT_J;
      len_acc   = 16'd0;
      digit_cnt = 3'd0;
      pay_cnt   = 16'd0;
   endtask

   task automatic deframe_step(input logic [7:0] b, output bit produced, output rsp_type r);
      logic [4:0] dig;
      produced = 1'b0;
      r = '0;
      if (b != CARRIAGE_RET) begin
         case (phase)
            PHASE_WAIT_J: begin
               if (b == SYNC_FIRST) phase = PHASE_WAIT_S;
            end
            PHASE_WAIT_S: begin
               if (b == SYNC_SECOND) begin
                  phase     = PHASE_LENGTH;
                  len_acc   = 16'd0;
                  digit_cnt = 3'd0;
               end else if (b != SYNC_FIRST) begin
                  phase = PHASE_WAIT_J;
               end
            end
            PHASE_LENGTH: begin
               dig = hex_digit(b);
               if (!dig[4]) begin
                  clear_frame();
                  produced = 1'b1;
                  r.length_error = 1'b1;
               end else begin
                  len_acc   = {len_acc[11:0], dig[3:0]};
                  digit_cnt = digit_cnt + 3'd1;
                  if (digit_cnt >= LENGTH_DIGITS) begin
                     phase   = PHASE_PAYLOAD;
                     pay_cnt = 16'd0;
                  end
               end
            end
            default: begin
               pay_cnt = pay_cnt + 16'd1;
               produced = 1'b1;
               r.payload_byte = b;
               r.frame_length = len_acc;
               r.byte_is_last = (pay_cnt >= len_acc) || (pay_cnt == 16'd0);
               if (r.byte_is_last) clear_frame();
            end
         endcase
      end
   endtask

   task automatic send_row(input stim_row_type row);
      while (!quiet && $urandom_range(0, 99) < 11) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= row.rx;
      row_typed   <= row.typed;
      row_rsp     <= row.rsp;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_row(pred_row(b));
   endtask

   task automatic sprinkle_cr;
      if ($urandom_range(0, 9) == 0) send_byte(CARRIAGE_RET);
   endtask

   task automatic send_hex(input logic [3:0] n);
      logic [7:0] b;
      if (n < 4'd10) begin
         b = 8'h30 + n;
      end else begin
         b = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
      end
      send_byte(b);
   endtask

   task automatic drain_results;
      req_valid <= 1'b0;
      do @(negedge clock); while (awaited_rsps.size() != 0);
   endtask

   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 11);
   end

   always @(posedge clock) begin : scoreboard
      bit      produced;
      rsp_type predicted;
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            deframe_step(req_rx_byte, produced, predicted);
            if (row_typed) begin
               awaited_rsps.push_back(row_rsp);
            end else if (produced) begin
               awaited_rsps.push_back(predicted);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsps.size() == 0) begin
               $error("result item with none expected");
               mismatch_count++;
            end else begin
               want = awaited_rsps.pop_front();
               if (rsp_payload_byte !== want.payload_byte) begin
                  $error("payload_byte expected %0h actual %0h",
                         want.payload_byte, rsp_payload_byte);
                  mismatch_count++;
               end
               if (rsp_byte_is_last !== want.byte_is_last) begin
                  $error("byte_is_last expected %0b actual %0b",
                         want.byte_is_last, rsp_byte_is_last);
                  mismatch_count++;
               end
               if (rsp_length_error !== want.length_error) begin
                  $error("length_error expected %0b actual %0b",
                         want.length_error, rsp_length_error);
                  mismatch_count++;
               end
               if (rsp_frame_length !== want.frame_length) begin
                  $error("frame_length expected %0h actual %0h",
                         want.frame_length, rsp_frame_length);
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin : stimulus
      logic [7:0] b;
      logic [4:0] h;
      int         random_count;
      int         frame_idx;
      int         len;
      int         kind;
      int         cut;
      int         sent;
      clear_frame();
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // cr and repeated sync, zero length with a cr among the digits
      directed_rows.push_back(pred_row(CARRIAGE_RET));
      directed_rows.push_back(pred_row(SYNC_FIRST));
      directed_rows.push_back(pred_row(SYNC_FIRST));
      directed_rows.push_back(pred_row(SYNC_SECOND));
      directed_rows.push_back(pred_row(8'h30));
      directed_rows.push_back(pred_row(8'h30));
      directed_rows.push_back(pred_row(8'h30));
      directed_rows.push_back(pred_row(CARRIAGE_RET));
      directed_rows.push_back(pred_row(8'h30));
      directed_rows.push_back(typed_row(8'hFF, 8'hFF, 1'b1, 1'b0, 16'h0000));
      // bad length character
      directed_rows.push_back(pred_row(SYNC_FIRST));
      directed_rows.push_back(pred_row(SYNC_SECOND));
      directed_rows.push_back(typed_row(8'h47, 8'h00, 1'b0, 1'b1, 16'h0000));
      // broken sync, then a two byte frame with a cr in its payload
      directed_rows.push_back(pred_row(SYNC_FIRST));
      directed_rows.push_back(pred_row(8'h78));
      directed_rows.push_back(pred_row(SYNC_FIRST));
      directed_rows.push_back(pred_row(SYNC_SECOND));
      directed_rows.push_back(pred_row(8'h30));
      directed_rows.push_back(pred_row(8'h30));
      directed_rows.push_back(pred_row(8'h30));
      directed_rows.push_back(pred_row(8'h32));
      directed_rows.push_back(pred_row(8'h00));
      directed_rows.push_back(pred_row(CARRIAGE_RET));
      directed_rows.push_back(typed_row(SYNC_FIRST, SYNC_FIRST, 1'b1, 1'b0, 16'h0002));
      // digits at the edges of the hex ranges, each frame aborted just outside a range
      directed_rows.push_back(pred_row(SYNC_FIRST));
      directed_rows.push_back(pred_row(SYNC_SECOND));
      directed_rows.push_back(pred_row(8'h46));
      directed_rows.push_back(pred_row(8'h66));
      directed_rows.push_back(pred_row(8'h39));
      directed_rows.push_back(typed_row(8'h67, 8'h00, 1'b0, 1'b1, 16'h0000));
      directed_rows.push_back(pred_row(SYNC_FIRST));
      directed_rows.push_back(pred_row(SYNC_SECOND));
      directed_rows.push_back(typed_row(8'h2F, 8'h00, 1'b0, 1'b1, 16'h0000));
      directed_rows.push_back(pred_row(SYNC_FIRST));
      directed_rows.push_back(pred_row(SYNC_SECOND));
      directed_rows.push_back(pred_row(8'h41));
      directed_rows.push_back(typed_row(8'h3A, 8'h00, 1'b0, 1'b1, 16'h0000));
      directed_rows.push_back(pred_row(SYNC_FIRST));
      directed_rows.push_back(pred_row(SYNC_SECOND));
      directed_rows.push_back(pred_row(8'h61));
      directed_rows.push_back(pred_row(8'h30));
      directed_rows.push_back(typed_row(8'h40, 8'h00, 1'b0, 1'b1, 16'h0000));
      directed_rows.push_back(pred_row(SYNC_FIRST));
      directed_rows.push_back(pred_row(SYNC_SECOND));
      directed_rows.push_back(typed_row(8'h60, 8'h00, 1'b0, 1'b1, 16'h0000));
      foreach (directed_rows[i]) send_row(directed_rows[i]);
      drain_results();

      random_count = 0;
      frame_idx = 0;
      while (random_count < 360) begin
         if (frame_idx == 12) drain_results();
         quiet = (frame_idx >= 16 && frame_idx < 28);
         repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
         kind = $urandom_range(0, 99);
         send_byte(SYNC_FIRST);
         random_count++;
         if ($urandom_range(0, 4) == 0) begin
            send_byte(SYNC_FIRST);
            random_count++;
         end
         if (kind < 8) begin
            b = 8'($urandom);
            if (b == SYNC_SECOND) b = 8'h00;
            send_byte(b);
            random_count++;
         end else begin
            sprinkle_cr();
            send_byte(SYNC_SECOND);
            random_count++;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
            cut = (kind < 20) ? $urandom_range(0, LENGTH_DIGITS - 1) : LENGTH_DIGITS;
            for (int d = 0; d < LENGTH_DIGITS; d++) begin
               sprinkle_cr();
               if (d < cut) begin
                  send_hex(4'(len >> (4 * (LENGTH_DIGITS - 1 - d))));
                  random_count++;
               end else if (d == cut) begin
                  do begin
                     b = 8'($urandom);
                     h = hex_digit(b);
                  end while (h[4] || b == CARRIAGE_RET);
                  send_byte(b);
                  random_count++;
               end
            end
            if (cut == LENGTH_DIGITS) begin
               sent = 0;
               while (sent < ((len == 0) ? 1 : len)) begin
                  sprinkle_cr();
                  b = 8'($urandom);
                  send_byte(b);
                  if (b != CARRIAGE_RET) sent++;
                  random_count++;
               end
            end
         end
         frame_idx++;
      end
      quiet = 1'b0;

      drain_results();
      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("FAIL");
      $finish;
   end

endmodule
